### src/ikr_pkg.sv
// ----------------------------------------------------------------------------
// ikr_pkg
// Shared types and constants for the IKE message redactor.
// ----------------------------------------------------------------------------
`default_nettype none

package ikr_pkg;

	// message geometry
	localparam logic [15:0] MAX_MSG_BYTES  = 16'hFFFF;
	localparam logic [15:0] HDR_MIN_BYTES  = 16'd28;
	localparam logic [15:0] POS_NEXT_TYPE  = 16'd16;
	localparam logic [15:0] POS_VERSION    = 16'd17;
	localparam logic [15:0] POS_FLAGS      = 16'd19;
	localparam logic [15:0] POS_SAT        = 16'hFFFF;
	localparam logic [15:0] GEN_HDR_BYTES  = 16'd4;

	// header values
	localparam logic [7:0] IKEV1_VERSION   = 8'h10;
	localparam logic [7:0] ENC_FLAG_CLEAR  = 8'hFE;

	// payload types
	localparam logic [7:0] PT_NONE         = 8'h00;
	localparam logic [7:0] PT_V1_HASH      = 8'h08;
	localparam logic [7:0] PT_V1_SIG       = 8'h09;
	localparam logic [7:0] PT_V1_RSV_MIN   = 8'h0E;
	localparam logic [7:0] PT_V2_ENC       = 8'h2E;
	localparam logic [7:0] PT_V2_AUTH      = 8'h27;
	localparam logic [7:0] PT_V2_EAP       = 8'h30;

	// IV sizes written into the encrypted payload length
	localparam logic [7:0] IV_DES_BYTES    = 8'h0C;
	localparam logic [7:0] IV_AES_BYTES    = 8'h14;

	// body offsets from which data is blanked
	localparam logic [3:0] SKIP_V1_BODY    = 4'd4;
	localparam logic [3:0] SKIP_V2_AUTH    = 4'd8;
	localparam logic [3:0] SKIP_V2_EAP     = 4'd9;

	// cipher kinds
	localparam logic [1:0] CK_DES          = 2'd0;
	localparam logic [1:0] CK_3DES         = 2'd1;
	localparam logic [1:0] CK_AES_CBC      = 2'd2;
	localparam logic [1:0] CK_OTHER        = 2'd3;

	// lookahead window: four held bytes plus the incoming one
	localparam int WIN_HELD   = 4;
	localparam int WIN_SLOTS  = WIN_HELD + 1;
	localparam int WIN_CNT_W  = $clog2(WIN_SLOTS + 1);

	// decoupling queues
	localparam int QDEPTH     = 2;
	localparam int QIDX_W     = $clog2(QDEPTH);
	localparam int QCNT_W     = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		MODE_PASS = 2'd0,
		MODE_V1   = 2'd1,
		MODE_V2   = 2'd2
	} mode_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        end_of_message;
		logic [15:0] message_length;
		logic [1:0]  cipher_kind;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} out_item_t;

	// handshake between a queue and the engine
	typedef struct packed {
		logic avail;
		logic full;
	} q_status_t;

endpackage

`default_nettype wire

### src/ikr_front.sv
// ----------------------------------------------------------------------------
// ikr_front
// Input side: accepts message bytes and holds them in a short queue
// ahead of the redaction engine.
// ----------------------------------------------------------------------------
`default_nettype none

module ikr_front import ikr_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire in_item_t  item_in,
	output q_status_t      status,
	input  wire logic      take,
	output in_item_t       item_out
);

	in_item_t              mem_q [QDEPTH];
	logic [QIDX_W-1:0]     wr_q;
	logic [QIDX_W-1:0]     rd_q;
	logic [QCNT_W-1:0]     cnt_q;
	logic                  do_wr;
	logic                  do_rd;

	assign status.full  = (cnt_q == QCNT_W'(QDEPTH));
	assign status.avail = (cnt_q != '0);
	assign do_wr        = push && !status.full;
	assign do_rd        = take && status.avail;
	assign item_out     = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wr_q <= (wr_q == QIDX_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_rd) begin
				rd_q <= (rd_q == QIDX_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			unique case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### src/ikr_outq.sv
// ----------------------------------------------------------------------------
// ikr_outq
// Output side: holds sanitized bytes until the receiver pops them.
// ----------------------------------------------------------------------------
`default_nettype none

module ikr_outq import ikr_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire out_item_t  item_in,
	output q_status_t       status,
	input  wire logic       pop,
	output out_item_t       item_out
);

	out_item_t             mem_q [QDEPTH];
	logic [QIDX_W-1:0]     wr_q;
	logic [QIDX_W-1:0]     rd_q;
	logic [QCNT_W-1:0]     cnt_q;
	logic                  do_wr;
	logic                  do_rd;

	assign status.full  = (cnt_q == QCNT_W'(QDEPTH));
	assign status.avail = (cnt_q != '0);
	assign do_wr        = push && !status.full;
	assign do_rd        = pop && status.avail;
	assign item_out     = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wr_q <= (wr_q == QIDX_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_rd) begin
				rd_q <= (rd_q == QIDX_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			unique case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### src/ikr_engine.sv
// ----------------------------------------------------------------------------
// ikr_engine
// Back end: lookahead window, payload walk and byte sanitizing. Emits at
// most one byte per cycle and drains the window at the end of a message.
// ----------------------------------------------------------------------------
`default_nettype none

module ikr_engine import ikr_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire q_status_t  in_stat,
	input  wire in_item_t   in_item,
	output logic            in_take,
	input  wire q_status_t  oq_stat,
	output logic            oq_push,
	output out_item_t       oq_item
);

	// window and drain control
	logic [7:0]            win_q [WIN_HELD];
	logic [WIN_CNT_W-1:0]  cnt_q;
	logic                  flush_q;
	logic [15:0]           flen_q;
	logic [1:0]            fkind_q;

	// walk state
	logic [15:0]           pos_q;
	mode_t                 mode_q;
	logic [7:0]            ptype_q;
	logic [16:0]           end_q;
	logic [16:0]           zfrom_q;
	logic                  zact_q;
	logic                  fin_q;
	logic                  zrem_q;

	logic [7:0]            wv [WIN_SLOTS];
	logic [7:0]            wm [WIN_SLOTS];
	logic [7:0]            wg [WIN_HELD];
	logic [WIN_CNT_W-1:0]  nv;
	logic [15:0]           len;
	logic [15:0]           in_len;
	logic [1:0]            kind;
	logic                  need_emit;
	logic                  go;
	logic                  do_emit;
	logic                  last;
	logic                  walk;
	logic [15:0]           rem;
	logic [15:0]           plen;
	logic [7:0]            nxt;
	logic [7:0]            iv_lo;
	logic [3:0]            skip;
	logic                  v1_blank_type;

	mode_t                 n_mode;
	logic [7:0]            n_ptype;
	logic [16:0]           n_end;
	logic [16:0]           n_zfrom;
	logic                  n_zact;
	logic                  n_fin;
	logic                  n_zrem;
	logic [7:0]            v;

	assign in_len = (in_item.message_length > MAX_MSG_BYTES) ? MAX_MSG_BYTES
	                                                          : in_item.message_length;

	// build the working window and decide whether a byte leaves this cycle
	always_comb begin
		for (int i = 0; i < WIN_HELD; i++) begin
			wv[i] = win_q[i];
		end
		wv[WIN_HELD] = '0;
		if (!flush_q) begin
			wv[cnt_q] = in_item.data_byte;
		end
		nv        = flush_q ? cnt_q : cnt_q + 1'b1;
		len       = flush_q ? flen_q : in_len;
		kind      = flush_q ? fkind_q : in_item.cipher_kind;
		need_emit = flush_q || (in_stat.avail &&
		            (nv == WIN_CNT_W'(WIN_SLOTS) || in_item.end_of_message));
		go        = flush_q ? !oq_stat.full
		                    : (in_stat.avail && (!need_emit || !oq_stat.full));
		in_take   = !flush_q && go;
		do_emit   = go && need_emit;
		last      = (nv == WIN_CNT_W'(1));
		for (int k = 0; k < WIN_HELD; k++) begin
			wg[k] = (WIN_CNT_W'(k) < nv) ? wv[k] : 8'h00;
		end
	end

	// payload walk and byte sanitizing for the front byte of the window
	always_comb begin
		wm      = wv;
		n_mode  = mode_q;
		n_ptype = ptype_q;
		n_end   = end_q;
		n_zfrom = zfrom_q;
		n_zact  = zact_q;
		n_fin   = fin_q;
		n_zrem  = zrem_q;
		rem     = (len > pos_q) ? len - pos_q : '0;
		plen    = {wg[2], wg[3]};
		nxt     = wg[0];
		skip    = '0;
		iv_lo   = wg[3];
		v1_blank_type = (ptype_q == PT_V1_HASH) || (ptype_q == PT_V1_SIG) ||
		                (ptype_q >= PT_V1_RSV_MIN);
		walk    = (mode_q != MODE_PASS) && !fin_q && (pos_q >= HDR_MIN_BYTES) &&
		          ({1'b0, pos_q} == end_q);

		if (pos_q == POS_NEXT_TYPE) begin
			n_ptype = wv[0];
			n_end   = {1'b0, HDR_MIN_BYTES};
			n_zact  = 1'b0;
			n_fin   = 1'b0;
		end else if (pos_q == POS_VERSION) begin
			if (len < HDR_MIN_BYTES) begin
				n_mode = MODE_PASS;
			end else begin
				n_mode = (wv[0] == IKEV1_VERSION) ? MODE_V1 : MODE_V2;
			end
		end

		if (walk) begin
			if (ptype_q == PT_NONE || rem <= GEN_HDR_BYTES) begin
				n_fin = 1'b1;
			end else begin
				n_zact = 1'b0;
				if (mode_q == MODE_V1) begin
					if (v1_blank_type) begin
						if (rem >= plen && plen >= GEN_HDR_BYTES) begin
							skip   = SKIP_V1_BODY;
							n_zact = 1'b1;
						end else begin
							n_zrem = 1'b1;
							nxt    = PT_NONE;
						end
					end
				end else begin
					if (ptype_q == PT_V2_ENC) begin
						// rewrite the length to the IV size
						if (kind == CK_DES || kind == CK_3DES) begin
							iv_lo = IV_DES_BYTES;
						end else if (kind == CK_AES_CBC) begin
							iv_lo = IV_AES_BYTES;
						end
						if (nv > WIN_CNT_W'(2)) begin
							wm[2] = 8'h00;
						end
						if (nv > WIN_CNT_W'(3)) begin
							wm[3] = iv_lo;
						end
						plen = {8'h00, iv_lo};
					end else if (ptype_q == PT_V2_AUTH) begin
						if (plen > 16'(SKIP_V2_AUTH) && rem >= plen) begin
							skip   = SKIP_V2_AUTH;
							n_zact = 1'b1;
						end
					end else if (ptype_q == PT_V2_EAP) begin
						if (plen > 16'(SKIP_V2_EAP) && rem >= plen) begin
							skip   = SKIP_V2_EAP;
							n_zact = 1'b1;
						end
					end
				end
				n_end   = {1'b0, pos_q} + {1'b0, plen};
				n_zfrom = {1'b0, pos_q} + 17'(skip);
				n_ptype = nxt;
				if (nxt == PT_NONE || rem < plen || plen < GEN_HDR_BYTES) begin
					n_fin = 1'b1;
				end
			end
		end

		v = wv[0];
		if (mode_q == MODE_V1 && pos_q == POS_FLAGS) begin
			v = v & ENC_FLAG_CLEAR;
		end
		// a walk cycle always sits at the payload start, so the held bounds suffice
		if (mode_q != MODE_PASS && zact_q && {1'b0, pos_q} >= zfrom_q &&
		    {1'b0, pos_q} < end_q) begin
			v = 8'h00;
		end
		if (n_zrem) begin
			v = 8'h00;
		end
	end

	assign oq_push          = do_emit;
	assign oq_item.out_byte = v;
	assign oq_item.out_last = last;

	always_ff @(posedge clk) begin
		if (do_emit) begin
			for (int i = 0; i < WIN_HELD; i++) begin
				win_q[i] <= wm[i + 1];
			end
		end else if (in_take) begin
			win_q[cnt_q[WIN_CNT_W-2:0]] <= in_item.data_byte;
		end
		if (in_take && in_item.end_of_message) begin
			flen_q  <= in_len;
			fkind_q <= in_item.cipher_kind;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			flush_q <= 1'b0;
			pos_q   <= '0;
			mode_q  <= MODE_PASS;
			ptype_q <= '0;
			end_q   <= '0;
			zfrom_q <= '0;
			zact_q  <= 1'b0;
			fin_q   <= 1'b0;
			zrem_q  <= 1'b0;
		end else if (do_emit && last) begin
			// final byte of the message: drop all message state
			cnt_q   <= '0;
			flush_q <= 1'b0;
			pos_q   <= '0;
			mode_q  <= MODE_PASS;
			ptype_q <= '0;
			end_q   <= '0;
			zfrom_q <= '0;
			zact_q  <= 1'b0;
			fin_q   <= 1'b0;
			zrem_q  <= 1'b0;
		end else if (do_emit) begin
			cnt_q   <= nv - 1'b1;
			if (in_take && in_item.end_of_message) begin
				flush_q <= 1'b1;
			end
			pos_q   <= (pos_q == POS_SAT) ? pos_q : pos_q + 1'b1;
			mode_q  <= n_mode;
			ptype_q <= n_ptype;
			end_q   <= n_end;
			zfrom_q <= n_zfrom;
			zact_q  <= n_zact;
			fin_q   <= n_fin;
			zrem_q  <= n_zrem;
		end else if (in_take) begin
			cnt_q <= nv;
		end
	end

endmodule

`default_nettype wire

### src/ike_message_redactor.sv
// ----------------------------------------------------------------------------
// ike_message_redactor
// Streams an IKE message byte by byte and returns a sanitized copy.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive data_byte, end_of_message, message_length and
//   cipher_kind with push; a beat is taken when push is high and full low.
//   Result channel: out_byte/out_last are valid while empty is low; a beat
//   is taken when pop is high and empty is low.
//   Each byte is held in a four-byte lookahead window so the generic header
//   of a payload is known before its first byte leaves. A byte therefore
//   leaves once four later bytes have arrived, or at end_of_message, which
//   drains the whole window; out_last marks the final byte of the message.
//   A releasing beat is written into the input queue; the engine then moves
//   the released byte into the output queue when it has room, and empty
//   goes low once it is there.
//   Throughput: one byte per cycle in and out unless the output queue fills
//   or a window drains. The engine emits at most one byte per cycle, so an
//   end_of_message beat holds the input while the window drains.
//   When pop is held low the output queue fills and the engine and input
//   queue stall in turn; no beat is lost. Reset clears all queues and the
//   walk state; a beat can be taken as soon as arst_n rises.
// ----------------------------------------------------------------------------
`default_nettype none

module ike_message_redactor import ikr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  data_byte,
	input  wire logic        end_of_message,
	input  wire logic [15:0] message_length,
	input  wire logic [1:0]  cipher_kind,
	output logic             empty,
	input  wire logic        pop,
	output logic [7:0]       out_byte,
	output logic             out_last
);

	in_item_t   in_item;
	in_item_t   eng_item;
	q_status_t  front_stat;
	q_status_t  outq_stat;
	logic       eng_take;
	logic       eng_push;
	out_item_t  eng_out;
	out_item_t  res_item;

	assign in_item.data_byte      = data_byte;
	assign in_item.end_of_message = end_of_message;
	assign in_item.message_length = message_length;
	assign in_item.cipher_kind    = cipher_kind;

	ikr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item_in  (in_item),
		.status   (front_stat),
		.take     (eng_take),
		.item_out (eng_item)
	);

	ikr_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_stat (front_stat),
		.in_item (eng_item),
		.in_take (eng_take),
		.oq_stat (outq_stat),
		.oq_push (eng_push),
		.oq_item (eng_out)
	);

	ikr_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (eng_push),
		.item_in  (eng_out),
		.status   (outq_stat),
		.pop      (pop),
		.item_out (res_item)
	);

	assign full     = front_stat.full;
	assign empty    = !outq_stat.avail;
	assign out_byte = res_item.out_byte;
	assign out_last = res_item.out_last;

endmodule

`default_nettype wire

### src/ikr_checker.sv
// ----------------------------------------------------------------------------
// ikr_checker
// Port-level checks for the IKE message redactor.
// ----------------------------------------------------------------------------
`default_nettype none

module ikr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        push,
	input wire logic        full,
	input wire logic        empty,
	input wire logic        pop,
	input wire logic [7:0]  out_byte,
	input wire logic        out_last
);

	// bytes accepted but not yet popped; the block holds at most eight
	logic [4:0] pend_q;
	logic       in_beat;
	logic       out_beat;

	assign in_beat  = push && !full;
	assign out_beat = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 5'(in_beat) - 5'(out_beat);
		end
	end

	a_no_invented_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat |-> (pend_q != '0))
		else $error("result beat with no byte outstanding");

	a_empty_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q == '0) |-> empty)
		else $error("result shown with no byte outstanding");

	a_bounded_storage: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 5'd8)
		else $error("more bytes held than the block can store");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(out_last)))
		else $error("waiting result changed before it was popped");

endmodule

bind ike_message_redactor ikr_checker u_ikr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.push     (push),
	.full     (full),
	.empty    (empty),
	.pop      (pop),
	.out_byte (out_byte),
	.out_last (out_last)
);

`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the IKE message redactor.
// Streams directed and random IKEv1, IKEv2, short and garbled messages
// through the push/full side. Each accepted byte goes into a scoreboard
// that keeps its own copy of the lookahead and payload walk, and every
// popped byte is compared against the oldest predicted byte.
// ----------------------------------------------------------------------------

import ikr_pkg::*;

class redactor_scoreboard;
	// walk state, mirrors the block
	int unsigned out_pos;
	mode_t       mode;
	bit [7:0]    next_type;
	int unsigned pl_start;
	int unsigned pl_size;
	int unsigned blank_from;
	bit          walk_done;
	bit          blank_rest;
	bit [7:0]    held[4];
	int unsigned held_cnt;
	// working window: held bytes plus the incoming one
	bit [7:0]    win[5];
	int unsigned win_n;

	out_item_t   due_bytes[$];
	int          errors;
	int          bytes_in;
	int          bytes_out;

	function new();
		clear_walk();
	endfunction

	function void clear_walk();
		out_pos = 0;
		mode = MODE_PASS;
		next_type = PT_NONE;
		pl_start = 0;
		pl_size = 0;
		blank_from = 0;
		walk_done = 1'b0;
		blank_rest = 1'b0;
		held_cnt = 0;
		foreach (held[i]) held[i] = 8'h00;
	endfunction

	function bit [7:0] win_at(int unsigned k);
		return (k < win_n) ? win[k] : 8'h00;
	endfunction

	// parse the generic header sitting at the front of the window
	function void walk_payload_header(int unsigned p, int unsigned len, bit [1:0] kind);
		int unsigned remain;
		int unsigned ptype;
		int unsigned plen;
		int unsigned nxt;
		int unsigned lo;
		remain = (len > p) ? len - p : 0;
		ptype = next_type;
		if (ptype == PT_NONE || remain <= GEN_HDR_BYTES) begin
			walk_done = 1'b1;
			return;
		end
		plen = {win_at(2), win_at(3)};
		nxt = win_at(0);
		blank_from = 0;
		if (mode == MODE_V1) begin
			if (ptype == PT_V1_HASH || ptype == PT_V1_SIG || ptype >= PT_V1_RSV_MIN) begin
				if (remain >= plen && plen >= GEN_HDR_BYTES) begin
					blank_from = SKIP_V1_BODY;
				end else begin
					// malformed: blank everything from here on
					blank_rest = 1'b1;
					nxt = PT_NONE;
				end
			end
		end else begin
			if (ptype == PT_V2_ENC) begin
				lo = win_at(3);
				if (kind == CK_DES || kind == CK_3DES) lo = IV_DES_BYTES;
				else if (kind == CK_AES_CBC) lo = IV_AES_BYTES;
				if (win_n > 2) win[2] = 8'h00;
				if (win_n > 3) win[3] = 8'(lo);
				plen = lo;
			end else if (ptype == PT_V2_AUTH) begin
				if (plen > SKIP_V2_AUTH && remain >= plen) blank_from = SKIP_V2_AUTH;
			end else if (ptype == PT_V2_EAP) begin
				if (plen > SKIP_V2_EAP && remain >= plen) blank_from = SKIP_V2_EAP;
			end
		end
		pl_start = p;
		pl_size = plen;
		next_type = 8'(nxt);
		if (nxt == PT_NONE || remain < plen || plen < GEN_HDR_BYTES) walk_done = 1'b1;
	endfunction

	// sanitized value of the byte at the front of the window
	function bit [7:0] release_front(int unsigned len, bit [1:0] kind);
		int unsigned p;
		bit [7:0] v;
		p = out_pos;
		if (p == POS_NEXT_TYPE) begin
			next_type = win[0];
			pl_start = HDR_MIN_BYTES;
			pl_size = 0;
			blank_from = 0;
			walk_done = 1'b0;
		end else if (p == POS_VERSION) begin
			if (len < HDR_MIN_BYTES) mode = MODE_PASS;
			else mode = (win[0] == IKEV1_VERSION) ? MODE_V1 : MODE_V2;
		end
		if (mode != MODE_PASS && !walk_done && p >= HDR_MIN_BYTES && p == pl_start + pl_size)
			walk_payload_header(p, len, kind);
		v = win[0];
		if (mode == MODE_V1 && p == POS_FLAGS) v &= ENC_FLAG_CLEAR;
		if (mode != MODE_PASS && blank_from != 0 &&
				p >= pl_start + blank_from && p < pl_start + pl_size)
			v = 8'h00;
		if (blank_rest) v = 8'h00;
		if (out_pos < POS_SAT) out_pos++;
		return v;
	endfunction

	function void shift_win();
		for (int i = 0; i + 1 < win_n; i++) win[i] = win[i + 1];
		win[win_n - 1] = 8'h00;
	endfunction

	function void accept_byte(logic [7:0] b, logic eom, logic [15:0] len16, logic [1:0] kind);
		int unsigned len;
		out_item_t item;
		len = len16;
		bytes_in++;
		foreach (win[i]) win[i] = 8'h00;
		win_n = (held_cnt > WIN_HELD) ? WIN_HELD : held_cnt;
		for (int i = 0; i < win_n; i++) win[i] = held[i];
		win[win_n] = b;
		win_n++;
		if (eom) begin
			// drain the whole window
			while (win_n > 0) begin
				item.out_byte = release_front(len, kind);
				item.out_last = (win_n == 1);
				due_bytes.push_back(item);
				shift_win();
				win_n--;
			end
			clear_walk();
			return;
		end
		if (win_n == WIN_SLOTS) begin
			item.out_byte = release_front(len, kind);
			item.out_last = 1'b0;
			due_bytes.push_back(item);
			shift_win();
			win_n = WIN_HELD;
		end
		for (int i = 0; i < WIN_HELD; i++) held[i] = (i < win_n) ? win[i] : 8'h00;
		held_cnt = win_n;
	endfunction

	function void check_byte(logic [7:0] got_byte, logic got_last);
		out_item_t want;
		bytes_out++;
		if (due_bytes.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("%t: byte %02h last %0b arrived with nothing expected",
					$time, got_byte, got_last);
			return;
		end
		want = due_bytes.pop_front();
		if (got_byte !== want.out_byte || got_last !== want.out_last) begin
			errors++;
			if (errors <= 10)
				$display("%t: output byte %0d: expected %02h last %0b, got %02h last %0b",
					$time, bytes_out, want.out_byte, want.out_last, got_byte, got_last);
		end
	endfunction
endclass

module testbench;

	localparam int RANDOM_BEATS = 420;
	localparam int HOLD_CYCLES  = 200;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 10;

	typedef enum int {
		FLAW_NONE,
		FLAW_BAD_LENGTH,
		FLAW_TRUNCATED,
		FLAW_OVERRUN
	} flaw_t;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [7:0]  data_byte;
	logic        end_of_message;
	logic [15:0] message_length;
	logic [1:0]  cipher_kind;
	logic        empty;
	logic        pop;
	logic [7:0]  out_byte;
	logic        out_last;

	redactor_scoreboard sb = new();

	bit [7:0]    msg_bytes[$];
	logic [15:0] msg_len;
	logic [1:0]  msg_kind;
	bit          steady;
	bit          hold_req;
	int          beats_sent;
	int          stall_cycles;
	int          idle_cycles;
	int          n_v1, n_v2, n_short, n_noise, n_flawed;

	ike_message_redactor u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.data_byte      (data_byte),
		.end_of_message (end_of_message),
		.message_length (message_length),
		.cipher_kind    (cipher_kind),
		.empty          (empty),
		.pop            (pop),
		.out_byte       (out_byte),
		.out_last       (out_last)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// sample both sides at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) sb.accept_byte(data_byte, end_of_message, message_length, cipher_kind);
			if (pop && !empty) sb.check_byte(out_byte, out_last);
			if (push && full) stall_cycles++;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%t: no beat moved for %0d cycles", $time, STALL_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// receiver: random pops, one long hold-off on request
	initial begin
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			pop <= steady || $urandom_range(99) >= 30;
		end
	end

	task automatic send_beat(input logic [7:0] b, input logic eom, input logic [15:0] len,
			input logic [1:0] kind);
		while (!steady && $urandom_range(99) < 30) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		data_byte <= b;
		end_of_message <= eom;
		message_length <= len;
		cipher_kind <= kind;
		@(posedge clk);
		while (full) @(posedge clk);
		beats_sent++;
		@(negedge clk);
	endtask

	// wobble: scramble length and cipher kind from beat to beat
	task automatic send_message(input bit wobble);
		for (int i = 0; i < msg_bytes.size(); i++)
			send_beat(msg_bytes[i], i == msg_bytes.size() - 1,
				(wobble && $urandom_range(3) == 0) ? 16'($urandom) : msg_len,
				wobble ? 2'($urandom) : msg_kind);
	endtask

	initial begin
		int          sel;
		int          k;
		int          body;
		int          start_beats;
		int          msg_idx;
		int unsigned bad_len;
		flaw_t       flaw;
		bit          is_v1;
		bit [7:0]    t;
		bit [7:0]    ver;
		bit [7:0]    types[$];

		arst_n = 1'b0;
		push = 1'b0;
		data_byte = 8'h00;
		end_of_message = 1'b0;
		message_length = 16'h0000;
		cipher_kind = CK_DES;
		steady = 1'b0;
		hold_req = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: single-byte messages, a drain with a partial window,
		// a large length on streams far too short to carry it
		msg_bytes = '{8'hFF};
		msg_len = 16'hFFFF;
		msg_kind = CK_OTHER;
		send_message(1'b0);
		msg_bytes = '{8'h00};
		msg_len = 16'h0000;
		msg_kind = CK_DES;
		send_message(1'b0);
		msg_bytes = '{8'hAA, 8'h55, 8'h0F, 8'hF0};
		msg_len = 16'd4;
		msg_kind = CK_3DES;
		send_message(1'b0);
		msg_bytes = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20};
		msg_len = 16'hFFFF;
		msg_kind = CK_AES_CBC;
		send_message(1'b0);
		msg_bytes = '{8'h40, 8'h80, 8'hFE, 8'h7F, 8'h00, 8'hFF, 8'h10, 8'h2E, 8'h27, 8'h30};
		msg_len = 16'h7FFF;
		msg_kind = CK_AES_CBC;
		send_message(1'b0);

		start_beats = beats_sent;
		msg_idx = 0;
		while (beats_sent - start_beats < RANDOM_BEATS) begin
			// the held-off message must be long enough to fill the block
			sel = (msg_idx == 1) ? $urandom_range(69) : $urandom_range(99);
			steady = (msg_idx >= 3 && msg_idx <= 5);
			msg_kind = 2'($urandom);
			msg_bytes.delete();
			if (sel < 70) begin
				is_v1 = (sel < 35);
				types.delete();
				k = $urandom_range(1, 3);
				for (int i = 0; i < k; i++) begin
					case ($urandom_range(3))
						0: t = is_v1 ? PT_V1_HASH : PT_V2_ENC;
						1: t = is_v1 ? PT_V1_SIG : PT_V2_AUTH;
						2: t = is_v1 ? 8'($urandom_range(PT_V1_RSV_MIN, 255)) : PT_V2_EAP;
						default: t = is_v1 ? 8'($urandom_range(1, 13)) : 8'($urandom_range(8'h21, 8'h2D));
					endcase
					types.push_back(t);
				end
				for (int i = 0; i < HDR_MIN_BYTES; i++) msg_bytes.push_back(8'($urandom));
				do ver = 8'($urandom); while (ver == IKEV1_VERSION);
				if ($urandom_range(1)) ver = 8'h20;
				msg_bytes[POS_NEXT_TYPE] = types[0];
				msg_bytes[POS_VERSION] = is_v1 ? IKEV1_VERSION : ver;
				for (int i = 0; i < k; i++) begin
					body = $urandom_range(0, 14);
					msg_bytes.push_back((i + 1 < k) ? types[i + 1] : PT_NONE);
					msg_bytes.push_back(8'($urandom));
					msg_bytes.push_back(8'((body + GEN_HDR_BYTES) >> 8));
					msg_bytes.push_back(8'(body + GEN_HDR_BYTES));
					for (int j = 0; j < body; j++) msg_bytes.push_back(8'($urandom));
				end
				msg_len = 16'(msg_bytes.size());
				flaw = ($urandom_range(99) < 65) ? FLAW_NONE : flaw_t'($urandom_range(1, 3));
				case (flaw)
					FLAW_BAD_LENGTH: begin
						// first payload claims too little or more than is left
						bad_len = $urandom_range(1) ? $urandom_range(3) :
							$urandom_range(msg_bytes.size(), 16'hFFFF);
						msg_bytes[HDR_MIN_BYTES + 2] = 8'(bad_len >> 8);
						msg_bytes[HDR_MIN_BYTES + 3] = 8'(bad_len);
					end
					FLAW_TRUNCATED: repeat ($urandom_range(1, 6)) void'(msg_bytes.pop_back());
					FLAW_OVERRUN: repeat ($urandom_range(1, 10)) msg_bytes.push_back(8'($urandom));
					default: ;
				endcase
				if (flaw != FLAW_NONE) n_flawed++;
				if (is_v1) n_v1++;
				else n_v2++;
			end else begin
				k = (sel < 85) ? $urandom_range(1, 27) : $urandom_range(1, 48);
				for (int i = 0; i < k; i++) msg_bytes.push_back(8'($urandom));
				if (k > POS_VERSION && $urandom_range(1)) msg_bytes[POS_VERSION] = IKEV1_VERSION;
				if (sel < 85) begin
					msg_len = $urandom_range(1) ? 16'(k) : 16'($urandom_range(27));
					n_short++;
				end else begin
					msg_len = 16'($urandom);
					n_noise++;
				end
			end
			if (msg_idx == 1) hold_req = 1'b1;
			send_message(sel >= 85);
			if (msg_idx == 2) begin
				// let the block drain completely before going on
				push <= 1'b0;
				do @(negedge clk); while (sb.due_bytes.size() != 0);
			end
			msg_idx++;
		end
		steady = 1'b0;

		push <= 1'b0;
		while (sb.due_bytes.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Covered %0d random messages: %0d IKEv1, %0d IKEv2, %0d short, %0d garbled, "
			, msg_idx, n_v1, n_v2, n_short, n_noise);
		$display("%0d with a bad length, truncation or overrun; %0d bytes in, %0d out, %0d stall cycles",
			n_flawed, sb.bytes_in, sb.bytes_out, stall_cycles);
		if (sb.errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
